/* hw/rtl/psc_pkg.sv */
package psc_pkg;

   // Configuration bus geometry: six 16-bit registers on a 32-bit bus
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REG_W     = 16;
   localparam int REG_COUNT = 6;
   localparam int INDEX_W   = ADDR_W - 2;

   // Register indexes
   localparam logic [INDEX_W-1:0] REG_SENS_COEF      = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_OFF_COEF       = INDEX_W'(1);
   localparam logic [INDEX_W-1:0] REG_SENS_TEMP_COEF = INDEX_W'(2);
   localparam logic [INDEX_W-1:0] REG_OFF_TEMP_COEF  = INDEX_W'(3);
   localparam logic [INDEX_W-1:0] REG_REF_TEMP_WORD  = INDEX_W'(4);
   localparam logic [INDEX_W-1:0] REG_TEMP_SLOPE     = INDEX_W'(5);

   // Compensation constants, hundredths of a degree
   localparam int TEMP_REF  = 2000;
   localparam int VERY_COLD = 1500;

   // Clock edges from the accepting edge to the edge that takes the result
   localparam int LATENCY = 9;

   typedef struct packed {
      logic [REG_W-1:0] sens_coef;
      logic [REG_W-1:0] off_coef;
      logic [REG_W-1:0] sens_temp_coef;
      logic [REG_W-1:0] off_temp_coef;
      logic [REG_W-1:0] ref_temp_word;
      logic [REG_W-1:0] temp_slope;
   } cal_type;

endpackage

/* hw/rtl/psc_pipe.sv */
module psc_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [23:0]              pressure_raw,
   input  logic [23:0]              temperature_raw,
   input  psc_pkg::cal_type         cal,
   output logic                     out_valid,
   output logic signed [18:0]       temp_first,
   output logic signed [31:0]       pres_first,
   output logic signed [18:0]       temp_second,
   output logic signed [31:0]       pres_second
);

   logic [psc_pkg::LATENCY-1:0] vld_ff;

   // stage 1
   logic [23:0]        d1_s1_ff;
   logic signed [24:0] dt_s1_ff, dt_in;
   // stage 2
   logic [23:0]        d1_s2_ff;
   logic signed [41:0] mslope_s2_ff, moff_s2_ff, msens_s2_ff;
   logic signed [41:0] mslope_in, moff_in, msens_in;
   logic signed [49:0] dtsq_s2_ff, dtsq_in;
   logic signed [16:0] tiq_s2_ff, tiq_in;
   // stage 3
   logic [23:0]        d1_s3_ff;
   logic signed [18:0] temp_s3_ff, temp_in;
   logic signed [35:0] off_s3_ff, off_in;
   logic signed [34:0] sens_s3_ff, sens_in;
   logic [13:0]        tiw_s3_ff, tiw_in;
   logic signed [19:0] tic_s3_ff, tic_in, tiq20;
   // stage 4
   logic [23:0]        d1_s4_ff;
   logic signed [18:0] temp_s4_ff, temp2_s4_ff, temp2_in;
   logic signed [35:0] off_s4_ff;
   logic signed [34:0] sens_s4_ff;
   logic [35:0]        dsq_s4_ff, csq_s4_ff, dsq_in, csq_in;
   logic               cold_s4_ff, vcold_s4_ff, cold_in, vcold_in;
   logic [40:0]        pp1lo_s4_ff, pp1lo_in;
   logic signed [42:0] pp1hi_s4_ff, pp1hi_in;
   logic signed [19:0] temp20, diff20, cdiff20, ti20, temp2_full;
   logic signed [39:0] dsq_full, csq_full;
   // stage 5
   logic [23:0]        d1_s5_ff;
   logic signed [18:0] temp_s5_ff, temp2_s5_ff;
   logic signed [35:0] off_s5_ff;
   logic signed [34:0] sens_s5_ff;
   logic [37:0]        offi_s5_ff, offi_in, d38, c38, off3, off7;
   logic [36:0]        sensi_s5_ff, sensi_in, d37, c37, sens5, sens4;
   logic signed [59:0] prod1_s5_ff, prod1_in, hi60;
   // stage 6
   logic [23:0]        d1_s6_ff;
   logic signed [18:0] temp_s6_ff, temp2_s6_ff;
   logic signed [26:0] p1_s6_ff, p1_in;
   logic signed [39:0] pdiff1;
   logic signed [38:0] sens2_s6_ff, sens2_in;
   logic signed [39:0] off2_s6_ff, off2_in;
   // stage 7
   logic signed [18:0] temp_s7_ff, temp2_s7_ff;
   logic signed [26:0] p1_s7_ff;
   logic signed [39:0] off2_s7_ff;
   logic [42:0]        pp2lo_s7_ff, pp2lo_in;
   logic signed [44:0] pp2hi_s7_ff, pp2hi_in;
   // stage 8
   logic signed [18:0] temp_s8_ff, temp2_s8_ff;
   logic signed [26:0] p1_s8_ff;
   logic signed [39:0] off2_s8_ff;
   logic signed [63:0] prod2_s8_ff, prod2_in, hi64;
   // stage 9
   logic signed [18:0] temp_s9_ff, temp2_s9_ff;
   logic signed [26:0] p1_s9_ff;
   logic signed [30:0] p2_s9_ff, p2_in;
   logic signed [43:0] pdiff2;

   // dT; with 24-bit conversions it always lies inside its clamp bounds,
   // and so do offset and sensitivity, so no saturation stage is built
   assign dt_in = $signed({1'b0, temperature_raw}) - $signed({1'b0, cal.ref_temp_word, 8'b0});

   // stage 1 -> 2: products of dT
   always_comb begin
      mslope_in = dt_s1_ff * $signed({1'b0, cal.temp_slope});
      moff_in   = dt_s1_ff * $signed({1'b0, cal.off_temp_coef});
      msens_in  = dt_s1_ff * $signed({1'b0, cal.sens_temp_coef});
      dtsq_in   = dt_s1_ff * dt_s1_ff;
      // bit slices give the floor shifts by 16 and 17
      tiq_in    = $signed(dt_s1_ff[24:16]) * $signed(dt_s1_ff[24:17]);
   end

   // stage 2 -> 3: first-order temperature, offset, sensitivity
   always_comb begin
      temp_in = 19'(psc_pkg::TEMP_REF) + $signed(mslope_s2_ff[41:23]);
      off_in  = $signed({4'b0, cal.off_coef, 16'b0}) + $signed(moff_s2_ff[41:7]);
      sens_in = $signed({4'b0, cal.sens_coef, 15'b0}) + $signed(msens_s2_ff[41:8]);
      tiw_in  = dtsq_s2_ff[49:36];
      tiq20   = tiq_s2_ff;
      tic_in  = (tiq20 <<< 1) + tiq20;
   end

   // stage 3 -> 4: squares, branch select, first pressure partial products
   always_comb begin
      temp20     = temp_s3_ff;
      diff20     = temp20 - 20'(psc_pkg::TEMP_REF);
      cdiff20    = temp20 + 20'(psc_pkg::VERY_COLD);
      dsq_full   = diff20 * diff20;
      csq_full   = cdiff20 * cdiff20;
      dsq_in     = dsq_full[35:0];
      csq_in     = csq_full[35:0];
      cold_in    = temp_s3_ff < 19'(psc_pkg::TEMP_REF);
      vcold_in   = temp_s3_ff < 19'(-psc_pkg::VERY_COLD);
      ti20       = cold_in ? tic_s3_ff : $signed({6'b0, tiw_s3_ff});
      temp2_full = temp20 - ti20;
      temp2_in   = temp2_full[18:0];
      pp1lo_in   = d1_s3_ff * sens_s3_ff[16:0];
      pp1hi_in   = $signed({1'b0, d1_s3_ff}) * $signed(sens_s3_ff[34:17]);
   end

   // stage 4 -> 5: second-order offset and sensitivity terms
   always_comb begin
      d38   = {2'b0, dsq_s4_ff};
      c38   = {2'b0, csq_s4_ff};
      d37   = {1'b0, dsq_s4_ff};
      c37   = {1'b0, csq_s4_ff};
      off3  = (d38 + (d38 << 1)) >> 1;
      off7  = (c38 << 3) - c38;
      sens5 = (d37 + (d37 << 2)) >> 3;
      sens4 = c37 << 2;
      if (cold_s4_ff) begin
         offi_in  = vcold_s4_ff ? off3 + off7 : off3;
         sensi_in = vcold_s4_ff ? sens5 + sens4 : sens5;
      end else begin
         offi_in  = d38 >> 4;
         sensi_in = '0;
      end
      hi60     = pp1hi_s4_ff;
      prod1_in = (hi60 <<< 17) + $signed({19'b0, pp1lo_s4_ff});
   end

   // stage 5 -> 6: first pressure, corrected offset and sensitivity
   always_comb begin
      pdiff1   = $signed(prod1_s5_ff[59:21]) - off_s5_ff;
      p1_in    = pdiff1[39:13];
      sens2_in = sens_s5_ff - $signed({2'b0, sensi_s5_ff});
      off2_in  = off_s5_ff - $signed({2'b0, offi_s5_ff});
   end

   // stage 6 -> 7 -> 8 -> 9: second pressure
   always_comb begin
      pp2lo_in = d1_s6_ff * sens2_s6_ff[18:0];
      pp2hi_in = $signed({1'b0, d1_s6_ff}) * $signed(sens2_s6_ff[38:19]);
      hi64     = pp2hi_s7_ff;
      prod2_in = (hi64 <<< 19) + $signed({21'b0, pp2lo_s7_ff});
      pdiff2   = $signed(prod2_s8_ff[63:21]) - off2_s8_ff;
      p2_in    = pdiff2[43:13];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[psc_pkg::LATENCY-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      d1_s1_ff     <= pressure_raw;
      dt_s1_ff     <= dt_in;

      d1_s2_ff     <= d1_s1_ff;
      mslope_s2_ff <= mslope_in;
      moff_s2_ff   <= moff_in;
      msens_s2_ff  <= msens_in;
      dtsq_s2_ff   <= dtsq_in;
      tiq_s2_ff    <= tiq_in;

      d1_s3_ff     <= d1_s2_ff;
      temp_s3_ff   <= temp_in;
      off_s3_ff    <= off_in;
      sens_s3_ff   <= sens_in;
      tiw_s3_ff    <= tiw_in;
      tic_s3_ff    <= tic_in;

      d1_s4_ff     <= d1_s3_ff;
      temp_s4_ff   <= temp_s3_ff;
      temp2_s4_ff  <= temp2_in;
      off_s4_ff    <= off_s3_ff;
      sens_s4_ff   <= sens_s3_ff;
      dsq_s4_ff    <= dsq_in;
      csq_s4_ff    <= csq_in;
      cold_s4_ff   <= cold_in;
      vcold_s4_ff  <= vcold_in;
      pp1lo_s4_ff  <= pp1lo_in;
      pp1hi_s4_ff  <= pp1hi_in;

      d1_s5_ff     <= d1_s4_ff;
      temp_s5_ff   <= temp_s4_ff;
      temp2_s5_ff  <= temp2_s4_ff;
      off_s5_ff    <= off_s4_ff;
      sens_s5_ff   <= sens_s4_ff;
      offi_s5_ff   <= offi_in;
      sensi_s5_ff  <= sensi_in;
      prod1_s5_ff  <= prod1_in;

      d1_s6_ff     <= d1_s5_ff;
      temp_s6_ff   <= temp_s5_ff;
      temp2_s6_ff  <= temp2_s5_ff;
      p1_s6_ff     <= p1_in;
      sens2_s6_ff  <= sens2_in;
      off2_s6_ff   <= off2_in;

      temp_s7_ff   <= temp_s6_ff;
      temp2_s7_ff  <= temp2_s6_ff;
      p1_s7_ff     <= p1_s6_ff;
      off2_s7_ff   <= off2_s6_ff;
      pp2lo_s7_ff  <= pp2lo_in;
      pp2hi_s7_ff  <= pp2hi_in;

      temp_s8_ff   <= temp_s7_ff;
      temp2_s8_ff  <= temp2_s7_ff;
      p1_s8_ff     <= p1_s7_ff;
      off2_s8_ff   <= off2_s7_ff;
      prod2_s8_ff  <= prod2_in;

      temp_s9_ff   <= temp_s8_ff;
      temp2_s9_ff  <= temp2_s8_ff;
      p1_s9_ff     <= p1_s8_ff;
      p2_s9_ff     <= p2_in;
   end

   assign out_valid   = vld_ff[psc_pkg::LATENCY-1];
   assign temp_first  = temp_s9_ff;
   assign temp_second = temp2_s9_ff;
   assign pres_first  = {{5{p1_s9_ff[26]}}, p1_s9_ff};
   assign pres_second = {p2_s9_ff[30], p2_s9_ff};

endmodule

/* hw/rtl/pressure_sensor_compensation.sv */
// Second-order pressure/temperature compensation for a 24-bit barometric sensor.
//
// Input: pulse start with req_pressure_raw and req_temperature_raw; the pair is
// taken at that edge. busy stays low, so a new pair may be started every cycle.
// Output: rsp_valid is high for exactly one cycle with the four results
// (first- and second-order temperature and pressure); the receiver cannot
// stall, so there is no backpressure and nothing is ever held.
// Timing: nine register stages, with no multiply wider than 25 x 25 bits.
// Throughput is one pair per cycle.
// Calibration: six 16-bit words on the APB port at byte addresses 0, 4, .. 20,
// readable; writes elsewhere are dropped. Change them only while no pair is in
// flight.
// Reset: synchronous, clears the calibration words to zero and empties the
// pipeline; no result strobe follows reset until a new start.
module pressure_sensor_compensation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [23:0]                       req_pressure_raw,
   input  logic [23:0]                       req_temperature_raw,
   output logic                              rsp_valid,
   output logic signed [18:0]                rsp_temp_first,
   output logic signed [31:0]                rsp_pres_first,
   output logic signed [18:0]                rsp_temp_second,
   output logic signed [31:0]                rsp_pres_second,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [psc_pkg::ADDR_W-1:0]        paddr,
   input  logic [psc_pkg::DATA_W-1:0]        pwdata,
   output logic [psc_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   psc_pkg::cal_type                cal_ff, cal_in;
   logic                            wr_en;
   logic [psc_pkg::INDEX_W-1:0]     index;
   logic [psc_pkg::REG_W-1:0]       rd_word;
   logic [psc_pkg::REG_W-1:0]       wr_word;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign wr_en   = psel & penable & pwrite & pready;
   assign index   = paddr[psc_pkg::ADDR_W-1:2];
   assign wr_word = pwdata[psc_pkg::REG_W-1:0];

   always_comb begin
      cal_in = cal_ff;
      if (wr_en) begin
         unique case (index)
            psc_pkg::REG_SENS_COEF:      cal_in.sens_coef      = wr_word;
            psc_pkg::REG_OFF_COEF:       cal_in.off_coef       = wr_word;
            psc_pkg::REG_SENS_TEMP_COEF: cal_in.sens_temp_coef = wr_word;
            psc_pkg::REG_OFF_TEMP_COEF:  cal_in.off_temp_coef  = wr_word;
            psc_pkg::REG_REF_TEMP_WORD:  cal_in.ref_temp_word  = wr_word;
            psc_pkg::REG_TEMP_SLOPE:     cal_in.temp_slope     = wr_word;
            default:                     cal_in = cal_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         psc_pkg::REG_SENS_COEF:      rd_word = cal_ff.sens_coef;
         psc_pkg::REG_OFF_COEF:       rd_word = cal_ff.off_coef;
         psc_pkg::REG_SENS_TEMP_COEF: rd_word = cal_ff.sens_temp_coef;
         psc_pkg::REG_OFF_TEMP_COEF:  rd_word = cal_ff.off_temp_coef;
         psc_pkg::REG_REF_TEMP_WORD:  rd_word = cal_ff.ref_temp_word;
         psc_pkg::REG_TEMP_SLOPE:     rd_word = cal_ff.temp_slope;
         default:                     rd_word = '0;
      endcase
   end

   assign prdata = {{(psc_pkg::DATA_W - psc_pkg::REG_W){1'b0}}, rd_word};

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   psc_pipe u_pipe (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start & ~busy),
      .pressure_raw    (req_pressure_raw),
      .temperature_raw (req_temperature_raw),
      .cal             (cal_ff),
      .out_valid       (rsp_valid),
      .temp_first      (rsp_temp_first),
      .pres_first      (rsp_pres_first),
      .temp_second     (rsp_temp_second),
      .pres_second     (rsp_pres_second)
   );

endmodule

/* hw/rtl/psc_checker.sv */
module psc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [18:0]                rsp_temp_first,
   input logic signed [18:0]                rsp_temp_second,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [psc_pkg::ADDR_W-1:0]        paddr,
   input logic [psc_pkg::DATA_W-1:0]        pwdata,
   input logic [psc_pkg::DATA_W-1:0]        prdata
);

   // every accepted pair produces its result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(psc_pkg::LATENCY) rsp_valid)
      else $error("accepted pair produced no result");

   // no result without a pair accepted the fixed latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, psc_pkg::LATENCY))
      else $error("result strobe without an accepted pair");

   // the second-order correction never raises the temperature
   a_temp_correction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_second <= rsp_temp_first)
      else $error("second-order temperature above first-order");

   // a read right after a write to the same register returns the written word
   a_readback: assert property (@(posedge clock) disable iff (reset)
      $past(psel && penable && pwrite) && psel && !pwrite && (paddr == $past(paddr))
      && ($past(paddr[psc_pkg::ADDR_W-1:2]) < psc_pkg::INDEX_W'(psc_pkg::REG_COUNT))
      |-> prdata == {{(psc_pkg::DATA_W - psc_pkg::REG_W){1'b0}},
                     $past(pwdata[psc_pkg::REG_W-1:0])})
      else $error("register readback mismatch");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_temp_first  (rsp_temp_first),
   .rsp_temp_second (rsp_temp_second),
   .psel            (psel),
   .penable         (penable),
   .pwrite          (pwrite),
   .paddr           (paddr),
   .pwdata          (pwdata),
   .prdata          (prdata)
);
